### rtl/tmoss_pkg.sv
// tmoss_pkg: shared types and constants of the trimmed-mean OCV/SOC estimator.
// Used by every module under rtl/. No dependencies.
package tmoss_pkg;

	localparam int SMP_W = 18;
	localparam int SOC_W = 17;
	localparam int OCV_W = 23;
	localparam int SER_W = 8;
	localparam int TEN_W = 5;
	localparam int IDX_W = 4;
	localparam int V_W = 28;
	localparam int BND_W = 24;
	localparam int DIV_NW = 48;
	localparam int DIV_DW = 24;
	localparam int DS_W = SOC_W + 1;
	localparam int DV_W = OCV_W + 1;
	localparam int NUM_W = DS_W + DV_W;
	localparam int RES_W = DIV_NW + 2;
	localparam int TRIM_DIV = 20;
	localparam int MEAN_SCALE = 1000;

	localparam logic [SOC_W-1:0] SOC_FULL = 17'd65536;
	localparam logic [SOC_W-1:0] SOC_DEFAULT = 17'd32768;

	localparam logic REG_SERIES = 1'b0;
	localparam logic REG_ENTRIES = 1'b1;

	localparam logic [SER_W-1:0] SERIES_RST = 8'd1;
	localparam logic [TEN_W-1:0] ENTRIES_RST = 5'd16;

	typedef enum logic [1:0] {
		DS_MEAN = 2'd0,
		DS_VOLT = 2'd1,
		DS_INTERP = 2'd2
	} div_sel_t;

	typedef enum logic [1:0] {
		OS_DEFAULT = 2'd0,
		OS_DIRECT = 2'd1,
		OS_INTERP = 2'd2
	} out_src_t;

	typedef struct packed {
		logic [SOC_W-1:0] soc;
		logic [OCV_W-1:0] ocv;
	} tbl_ent_t;

	typedef struct packed {
		logic smp_write;
		logic tbl_write;
		logic scan_start;
		logic scan_run;
		logic div_start;
		div_sel_t div_sel;
		logic mean_load;
		logic v_load;
		logic walk_start;
		logic walk_run;
		logic interp_load;
		logic num_load;
		logic out_load;
		out_src_t out_src;
	} tmoss_cmd_t;

	typedef struct packed {
		logic dflt;
		logic scan_done;
		logic div_done;
		logic walk_done;
		logic direct;
	} tmoss_stat_t;

endpackage

### rtl/tmoss_div.sv
// tmoss_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on tmoss_pkg for operand widths.
module tmoss_div import tmoss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output logic              done,
	output logic [DIV_NW-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [DIV_DW:0]   rem_sh;
	logic [DIV_DW:0]   dif;
	logic              ge;

	assign rem_sh = {rem_q, quo_q[DIV_NW-1]};
	assign dif = rem_sh - {1'b0, dvs_q};
	assign ge = !dif[DIV_DW];

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[DIV_NW-2:0], ge};
			rem_q <= ge ? dif[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == CNT_W'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

### rtl/tmoss_dp.sv
// tmoss_dp: estimator datapath - table and sample stores, set statistics,
// trim scan, table walk, interpolation and result registers. Uses tmoss_div, tmoss_pkg.
module tmoss_dp import tmoss_pkg::*; #(
	parameter int TABLE_DEPTH = 16,
	parameter int MAX_SAMPLES = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tmoss_cmd_t       cmd,
	output tmoss_stat_t      st,
	input  logic [IDX_W-1:0] entry_index,
	input  logic [SOC_W-1:0] entry_soc,
	input  logic [OCV_W-1:0] entry_ocv_uv,
	input  logic [SMP_W-1:0] pack_sample_mv,
	input  logic [SER_W-1:0] cells_in_series,
	input  logic [TEN_W-1:0] table_entries,
	output logic             done,
	output logic [SOC_W-1:0] soc_estimate,
	output logic             used_default,
	output logic             sample_overflow
);

	localparam int TIW = $clog2(TABLE_DEPTH);
	localparam int NW = $clog2(TABLE_DEPTH + 1);
	localparam int SIW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int SUMW = SMP_W + CW;

	// stores
	tbl_ent_t         tbl_mem [TABLE_DEPTH];
	logic [SMP_W-1:0] smp_mem [MAX_SAMPLES];
	tbl_ent_t         tbl_rd_q;
	logic [SMP_W-1:0] smp_rd_q;

	// set statistics
	logic [CW-1:0]    held_q;
	logic [SMP_W-1:0] min_q;
	logic [SMP_W-1:0] max_q;
	logic [SUMW-1:0]  sum_q;
	logic             ovf_q;
	logic             full;

	// trim scan
	logic [BND_W-1:0] lo_q;
	logic [BND_W-1:0] hi_q;
	logic [CW-1:0]    smp_iss_q;
	logic             smp_pend_q;
	logic [SUMW-1:0]  tsum_q;
	logic [CW-1:0]    tcnt_q;
	logic [BND_W-1:0] v20;

	// conversion and walk
	logic [SMP_W-1:0] mean_q;
	logic [V_W-1:0]   v_q;
	logic [NW-1:0]    n_use;
	logic [NW-1:0]    tbl_iss_q;
	logic             tbl_pend_q;
	logic [NW-1:0]    tbl_rk_q;
	logic             found_q;
	tbl_ent_t         e0_q, e1_q, el_q, pa_q, pb_q, prev_q;
	logic             hit;

	// interpolation
	tbl_ent_t                sa, sb;
	logic                    below, above;
	logic signed [DS_W-1:0]  ds_q;
	logic signed [DV_W-1:0]  dv_q;
	logic signed [DV_W-1:0]  dd_q;
	logic [SOC_W-1:0]        s0_q;
	logic                    direct_q;
	logic [SOC_W-1:0]        direct_soc_q;
	logic signed [NUM_W-1:0] num_q;
	logic [NUM_W-1:0]        num_mag;
	logic [DV_W-1:0]         den_mag;
	logic                    neg;
	logic signed [RES_W-1:0] q_s, res_s;
	logic [SOC_W-1:0]        interp_soc;

	// divider
	logic [DIV_NW-1:0] div_a;
	logic [DIV_DW-1:0] div_b;
	logic              div_done;
	logic [DIV_NW-1:0] div_q;

	// outputs
	logic             done_q;
	logic [SOC_W-1:0] soc_q;
	logic             dflt_q;
	logic             ovfo_q;

	function automatic logic [SOC_W-1:0] clamp_u(input logic [SOC_W-1:0] s);
		clamp_u = (s > SOC_FULL) ? SOC_FULL : s;
	endfunction

	assign full = (held_q == CW'(MAX_SAMPLES));
	assign n_use = (32'(table_entries) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(table_entries);

	// ---------------- stores ----------------
	always_ff @(posedge clk) begin
		if (cmd.tbl_write && (32'(entry_index) < TABLE_DEPTH)) begin
			tbl_mem[TIW'(entry_index)] <= '{soc: entry_soc, ocv: entry_ocv_uv};
		end
		tbl_rd_q <= tbl_mem[tbl_iss_q[TIW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.smp_write && !full) begin
			smp_mem[held_q[SIW-1:0]] <= pack_sample_mv;
		end
		smp_rd_q <= smp_mem[smp_iss_q[SIW-1:0]];
	end

	// ---------------- set statistics ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			min_q <= '0;
			max_q <= '0;
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.out_load) begin
			held_q <= '0;
			min_q <= '0;
			max_q <= '0;
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.smp_write) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				held_q <= held_q + CW'(1);
				sum_q <= sum_q + SUMW'(pack_sample_mv);
				if (held_q == '0 || pack_sample_mv < min_q) min_q <= pack_sample_mv;
				if (held_q == '0 || pack_sample_mv > max_q) max_q <= pack_sample_mv;
			end
		end
	end

	// ---------------- trim scan ----------------
	assign v20 = BND_W'(smp_rd_q) * BND_W'(TRIM_DIV);

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			lo_q <= BND_W'(min_q) * BND_W'(TRIM_DIV) + BND_W'(max_q - min_q);
			hi_q <= BND_W'(max_q) * BND_W'(TRIM_DIV) - BND_W'(max_q - min_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_iss_q <= '0;
			smp_pend_q <= 1'b0;
			tsum_q <= '0;
			tcnt_q <= '0;
		end else if (cmd.scan_start) begin
			smp_iss_q <= '0;
			smp_pend_q <= 1'b0;
			tsum_q <= '0;
			tcnt_q <= '0;
		end else if (cmd.scan_run) begin
			smp_pend_q <= (smp_iss_q < held_q);
			if (smp_iss_q < held_q) smp_iss_q <= smp_iss_q + CW'(1);
			if (smp_pend_q && v20 >= lo_q && v20 <= hi_q) begin
				tsum_q <= tsum_q + SUMW'(smp_rd_q);
				tcnt_q <= tcnt_q + CW'(1);
			end
		end
	end

	// ---------------- divider operands ----------------
	always_comb begin
		case (cmd.div_sel)
			DS_MEAN: begin
				div_a = (tcnt_q != '0) ? DIV_NW'(tsum_q) : DIV_NW'(sum_q);
				div_b = (tcnt_q != '0) ? DIV_DW'(tcnt_q) : DIV_DW'(held_q);
			end
			DS_VOLT: begin
				div_a = DIV_NW'(mean_q) * DIV_NW'(MEAN_SCALE);
				div_b = DIV_DW'(cells_in_series);
			end
			DS_INTERP: begin
				div_a = DIV_NW'(num_mag);
				div_b = DIV_DW'(den_mag);
			end
			default: begin
				div_a = '0;
				div_b = '0;
			end
		endcase
	end

	tmoss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk) begin
		if (cmd.mean_load) mean_q <= div_q[SMP_W-1:0];
		if (cmd.v_load) v_q <= div_q[V_W-1:0];
	end

	// ---------------- table walk ----------------
	// a segment brackets v when prev.ocv >= v >= cur.ocv; first hit wins
	assign hit = (tbl_rk_q != '0) && !found_q
		&& (v_q <= V_W'(prev_q.ocv)) && (v_q >= V_W'(tbl_rd_q.ocv));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_iss_q <= '0;
			tbl_pend_q <= 1'b0;
			tbl_rk_q <= '0;
			found_q <= 1'b0;
		end else if (cmd.walk_start) begin
			tbl_iss_q <= '0;
			tbl_pend_q <= 1'b0;
			tbl_rk_q <= '0;
			found_q <= 1'b0;
		end else if (cmd.walk_run) begin
			tbl_pend_q <= (tbl_iss_q < n_use);
			if (tbl_iss_q < n_use) tbl_iss_q <= tbl_iss_q + NW'(1);
			if (tbl_pend_q) begin
				tbl_rk_q <= tbl_rk_q + NW'(1);
				if (hit) found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_run && tbl_pend_q) begin
			prev_q <= tbl_rd_q;
			if (tbl_rk_q == NW'(0)) e0_q <= tbl_rd_q;
			if (tbl_rk_q == NW'(1)) e1_q <= tbl_rd_q;
			if (tbl_rk_q == n_use - NW'(1)) el_q <= tbl_rd_q;
			if (hit) begin
				pa_q <= prev_q;
				pb_q <= tbl_rd_q;
			end
		end
	end

	// ---------------- interpolation ----------------
	assign sa = found_q ? pa_q : e0_q;
	assign sb = found_q ? pb_q : e1_q;
	assign below = (v_q <= V_W'(el_q.ocv));
	assign above = (v_q >= V_W'(e0_q.ocv));

	always_ff @(posedge clk) begin
		if (cmd.interp_load) begin
			ds_q <= $signed({1'b0, sb.soc}) - $signed({1'b0, sa.soc});
			// v is below the first OCV here, so its low bits hold it exactly
			dv_q <= $signed({1'b0, v_q[OCV_W-1:0]}) - $signed({1'b0, sa.ocv});
			dd_q <= $signed({1'b0, sb.ocv}) - $signed({1'b0, sa.ocv});
			s0_q <= sa.soc;
			if (below) direct_soc_q <= clamp_u(e0_q.soc);
			else if (above) direct_soc_q <= clamp_u(el_q.soc);
			else direct_soc_q <= clamp_u(sa.soc);
		end
		if (cmd.num_load) num_q <= ds_q * dv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direct_q <= 1'b0;
		end else if (cmd.interp_load) begin
			direct_q <= below || above || (sb.ocv == sa.ocv);
		end
	end

	assign num_mag = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
	assign den_mag = dd_q[DV_W-1] ? DV_W'(-dd_q) : DV_W'(dd_q);
	assign neg = num_q[NUM_W-1] ^ dd_q[DV_W-1];
	assign q_s = $signed(RES_W'(div_q));

	always_comb begin
		res_s = $signed(RES_W'(s0_q)) + (neg ? -q_s : q_s);
		if (res_s < 0) interp_soc = '0;
		else if (res_s > $signed(RES_W'(SOC_FULL))) interp_soc = SOC_FULL;
		else interp_soc = res_s[SOC_W-1:0];
	end

	// ---------------- result ----------------
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ovfo_q <= ovf_q;
			case (cmd.out_src)
				OS_DEFAULT: begin
					soc_q <= SOC_DEFAULT;
					dflt_q <= 1'b1;
				end
				OS_DIRECT: begin
					soc_q <= direct_soc_q;
					dflt_q <= 1'b0;
				end
				OS_INTERP: begin
					soc_q <= interp_soc;
					dflt_q <= 1'b0;
				end
				default: begin
					soc_q <= SOC_DEFAULT;
					dflt_q <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= cmd.out_load;
	end

	assign st.dflt = (cells_in_series == '0) || (held_q == '0) || (n_use < NW'(2));
	assign st.scan_done = (smp_iss_q == held_q) && !smp_pend_q;
	assign st.div_done = div_done;
	assign st.walk_done = (tbl_iss_q == n_use) && !tbl_pend_q;
	assign st.direct = direct_q;

	assign done = done_q;
	assign soc_estimate = soc_q;
	assign used_default = dflt_q;
	assign sample_overflow = ovfo_q;

endmodule

### rtl/tmoss_ctrl.sv
// tmoss_ctrl: estimator sequencer, issues datapath commands per step.
// Depends on tmoss_pkg for the command and status structs.
module tmoss_ctrl import tmoss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        action,
	input  logic        is_last,
	input  tmoss_stat_t st,
	output tmoss_cmd_t  cmd,
	output logic        busy
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_EVAL   = 10'b00_0000_0010,
		S_SCAN   = 10'b00_0000_0100,
		S_MDIV   = 10'b00_0000_1000,
		S_VSTART = 10'b00_0001_0000,
		S_VDIV   = 10'b00_0010_0000,
		S_WALK   = 10'b00_0100_0000,
		S_IMUL   = 10'b00_1000_0000,
		S_ISTART = 10'b01_0000_0000,
		S_IDIV   = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.smp_write = action;
					cmd.tbl_write = !action;
					if (action && is_last) state_nxt = S_EVAL;
				end
			end
			S_EVAL: begin
				if (st.dflt) begin
					cmd.out_load = 1'b1;
					cmd.out_src = OS_DEFAULT;
					state_nxt = S_IDLE;
				end else begin
					cmd.scan_start = 1'b1;
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (st.scan_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel = DS_MEAN;
					state_nxt = S_MDIV;
				end
			end
			S_MDIV: begin
				if (st.div_done) begin
					cmd.mean_load = 1'b1;
					state_nxt = S_VSTART;
				end
			end
			S_VSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = DS_VOLT;
				state_nxt = S_VDIV;
			end
			S_VDIV: begin
				if (st.div_done) begin
					cmd.v_load = 1'b1;
					cmd.walk_start = 1'b1;
					state_nxt = S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk_run = 1'b1;
				if (st.walk_done) begin
					cmd.interp_load = 1'b1;
					state_nxt = S_IMUL;
				end
			end
			S_IMUL: begin
				if (st.direct) begin
					cmd.out_load = 1'b1;
					cmd.out_src = OS_DIRECT;
					state_nxt = S_IDLE;
				end else begin
					cmd.num_load = 1'b1;
					state_nxt = S_ISTART;
				end
			end
			S_ISTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = DS_INTERP;
				state_nxt = S_IDIV;
			end
			S_IDIV: begin
				cmd.div_sel = DS_INTERP;
				if (st.div_done) begin
					cmd.out_load = 1'b1;
					cmd.out_src = OS_INTERP;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nxt;
	end

	assign busy = (state_q != S_IDLE);

endmodule

### rtl/trimmed_mean_ocv_soc_estimator.sv
// Top level of the trimmed-mean OCV-to-SOC estimator: config registers,
// sequencer and datapath. Depends on tmoss_pkg, tmoss_ctrl, tmoss_dp, tmoss_div.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+------------------------------------------
//  config   | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//  item in  | start (taken when busy is low)  | action, entry_index, entry_soc,
//           |                                 | entry_ocv_uv, pack_sample_mv, is_last
//  result   | done, one-cycle strobe          | soc_estimate, used_default, sample_overflow
//
// Table writes and non-final samples are taken back to back; busy stays low for them.
// A final sample keeps busy high through at most:
// a sample-store walk (held samples), a table walk (n entries in use) and up
// to three passes of the shared 48-step serial divider; a result taken straight
// from the table skips the last pass. A default estimate holds busy high only
// for the evaluation state. done rises in the same cycle that busy drops.
// Reset is asynchronous, active low; no clearing pass. The result cannot be held off.
module trimmed_mean_ocv_soc_estimator import tmoss_pkg::*; #(
	parameter int TABLE_DEPTH = 16,
	parameter int MAX_SAMPLES = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             start,
	output logic             busy,
	input  logic             action,
	input  logic [IDX_W-1:0] entry_index,
	input  logic [SOC_W-1:0] entry_soc,
	input  logic [OCV_W-1:0] entry_ocv_uv,
	input  logic [SMP_W-1:0] pack_sample_mv,
	input  logic             is_last,
	output logic             done,
	output logic [SOC_W-1:0] soc_estimate,
	output logic             used_default,
	output logic             sample_overflow
);

	logic [SER_W-1:0] series_q;
	logic [TEN_W-1:0] entries_q;
	tmoss_cmd_t       cmd;
	tmoss_stat_t      st;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_q <= SERIES_RST;
			entries_q <= ENTRIES_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_SERIES: series_q <= pwdata[SER_W-1:0];
				REG_ENTRIES: entries_q <= pwdata[TEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SERIES: prdata = 32'(series_q);
			REG_ENTRIES: prdata = 32'(entries_q);
			default: prdata = '0;
		endcase
	end

	tmoss_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.action  (action),
		.is_last (is_last),
		.st      (st),
		.cmd     (cmd),
		.busy    (busy)
	);

	tmoss_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.entry_index     (entry_index),
		.entry_soc       (entry_soc),
		.entry_ocv_uv    (entry_ocv_uv),
		.pack_sample_mv  (pack_sample_mv),
		.cells_in_series (series_q),
		.table_entries   (entries_q),
		.done            (done),
		.soc_estimate    (soc_estimate),
		.used_default    (used_default),
		.sample_overflow (sample_overflow)
	);

	// a result always closes an estimate run
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding estimate run");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_default_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && used_default) |-> (soc_estimate == SOC_DEFAULT))
		else $error("default flag with non-default estimate");

	a_soc_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (soc_estimate <= SOC_FULL))
		else $error("estimate above full scale");

endmodule

### sim/trimmed_mean_ocv_soc_estimator_tb.sv
// Self-checking testbench for trimmed_mean_ocv_soc_estimator: table loads, sample sets,
// APB register phases, with an in-bench SOC predictor. Depends on tmoss_pkg and the RTL.
`timescale 1ns / 1ps

module trimmed_mean_ocv_soc_estimator_tb;
	import tmoss_pkg::*;

	localparam logic ACT_TABLE = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;
	localparam logic [2:0] ADDR_SERIES = {REG_SERIES, 2'b00};
	localparam logic [2:0] ADDR_ENTRIES = {REG_ENTRIES, 2'b00};
	localparam int TBL_DEPTH = 16;
	localparam int STORE_DEPTH = 128;
	localparam int SETTLE_CYCLES = 400;
	localparam int SMP_MAX = 262143;
	localparam int PHASE_ITEMS = 62;

	typedef struct {
		logic             act;
		logic [IDX_W-1:0] idx;
		logic [SOC_W-1:0] esoc;
		logic [OCV_W-1:0] eocv;
		logic [SMP_W-1:0] smp;
		logic             last;
	} op_t;

	typedef struct {
		logic [SOC_W-1:0] soc;
		logic             dflt;
		logic             ovf;
	} estimate_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic action = 1'b0;
	logic [IDX_W-1:0] entry_index = '0;
	logic [SOC_W-1:0] entry_soc = '0;
	logic [OCV_W-1:0] entry_ocv_uv = '0;
	logic [SMP_W-1:0] pack_sample_mv = '0;
	logic is_last = 1'b0;
	logic done;
	logic [SOC_W-1:0] soc_estimate;
	logic used_default;
	logic sample_overflow;

	trimmed_mean_ocv_soc_estimator dut (.*);

	always #6 clk = ~clk;

	// predictor state
	logic [SER_W-1:0] cfg_series = SERIES_RST;
	logic [TEN_W-1:0] cfg_entries = ENTRIES_RST;
	logic [SOC_W-1:0] cell_soc [TBL_DEPTH];
	logic [OCV_W-1:0] cell_ocv [TBL_DEPTH];
	logic [SMP_W-1:0] held_smp [STORE_DEPTH];
	int held_cnt = 0;
	longint run_min = 0, run_max = 0, run_sum = 0;
	logic ovf_seen = 1'b0;

	op_t pending_ops[$];
	estimate_t soc_expect[$];
	op_t cur_op;
	int mismatches = 0;
	bit no_idle = 0;

	// stimulus-side view of the table, used to aim samples into it
	logic [OCV_W-1:0] gen_ocv [TBL_DEPTH];
	int gen_series = 1;
	int items_made = 0;

	function automatic logic [SOC_W-1:0] clamp_soc(input longint s);
		if (s < 0)
			return '0;
		if (s > 65536)
			return SOC_FULL;
		return s[SOC_W-1:0];
	endfunction

	function automatic logic [SOC_W-1:0] table_lookup(input longint v, input int n);
		int seg;
		bit found;
		longint v0, v1, s0, s1, den;
		seg = 0;
		found = 0;
		if (v <= longint'(cell_ocv[n-1]))
			return clamp_soc(longint'(cell_soc[0]));
		if (v >= longint'(cell_ocv[0]))
			return clamp_soc(longint'(cell_soc[n-1]));
		for (int i = 0; i + 1 < n; i++) begin
			if (!found && v <= longint'(cell_ocv[i]) && v >= longint'(cell_ocv[i+1])) begin
				seg = i;
				found = 1;
			end
		end
		v0 = longint'(cell_ocv[seg]);
		v1 = longint'(cell_ocv[seg+1]);
		s0 = longint'(cell_soc[seg]);
		s1 = longint'(cell_soc[seg+1]);
		den = v1 - v0;
		if (den == 0)
			return clamp_soc(s0);
		return clamp_soc(s0 + ((s1 - s0) * (v - v0)) / den);
	endfunction

	task automatic apply_op(input op_t o);
		int n;
		longint span, lo, hi, tsum, mean, v20;
		int cnt;
		estimate_t e;
		if (o.act == ACT_TABLE) begin
			cell_soc[o.idx] = o.esoc;
			cell_ocv[o.idx] = o.eocv;
			return;
		end
		if (held_cnt < STORE_DEPTH) begin
			held_smp[held_cnt] = o.smp;
			if (held_cnt == 0) begin
				run_min = longint'(o.smp);
				run_max = longint'(o.smp);
			end else begin
				if (longint'(o.smp) < run_min) run_min = longint'(o.smp);
				if (longint'(o.smp) > run_max) run_max = longint'(o.smp);
			end
			run_sum += longint'(o.smp);
			held_cnt++;
		end else begin
			ovf_seen = 1'b1;
		end
		if (!o.last)
			return;
		n = (int'(cfg_entries) > TBL_DEPTH) ? TBL_DEPTH : int'(cfg_entries);
		if (cfg_series == 0 || held_cnt == 0 || n < 2) begin
			e.soc = SOC_DEFAULT;
			e.dflt = 1'b1;
		end else begin
			// trim band compared at 20x scale
			span = run_max - run_min;
			lo = 20 * run_min + span;
			hi = 20 * run_max - span;
			tsum = 0;
			cnt = 0;
			for (int i = 0; i < held_cnt; i++) begin
				v20 = 20 * longint'(held_smp[i]);
				if (v20 >= lo && v20 <= hi) begin
					tsum += longint'(held_smp[i]);
					cnt++;
				end
			end
			mean = (cnt > 0) ? tsum / cnt : run_sum / held_cnt;
			e.soc = table_lookup(mean * 1000 / longint'(cfg_series), n);
			e.dflt = 1'b0;
		end
		e.ovf = ovf_seen;
		soc_expect.push_back(e);
		held_cnt = 0;
		run_min = 0;
		run_max = 0;
		run_sum = 0;
		ovf_seen = 1'b0;
	endtask

	// driver: a transfer happens at an edge with start high and busy low
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				apply_op(cur_op);
			if (!(start && busy)) begin
				if (pending_ops.size() > 0 && (no_idle || $urandom_range(99) >= 37)) begin
					cur_op = pending_ops.pop_front();
					start <= 1'b1;
					action <= cur_op.act;
					entry_index <= cur_op.idx;
					entry_soc <= cur_op.esoc;
					entry_ocv_uv <= cur_op.eocv;
					pack_sample_mv <= cur_op.smp;
					is_last <= cur_op.last;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		estimate_t e;
		if (arst_n && done) begin
			if (soc_expect.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: soc=%0d dflt=%0b ovf=%0b",
						soc_estimate, used_default, sample_overflow);
			end else begin
				e = soc_expect.pop_front();
				if (soc_estimate !== e.soc || used_default !== e.dflt
						|| sample_overflow !== e.ovf) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp soc=%0d dflt=%0b ovf=%0b, got soc=%0d dflt=%0b ovf=%0b",
							e.soc, e.dflt, e.ovf, soc_estimate, used_default, sample_overflow);
				end
			end
		end
	end

	task automatic add_op(input logic act, input int idx, input longint esoc,
			input longint eocv, input longint smp, input logic last);
		op_t o;
		o.act = act;
		o.idx = IDX_W'(idx);
		o.esoc = SOC_W'(esoc);
		o.eocv = OCV_W'(eocv);
		o.smp = SMP_W'(smp);
		o.last = last;
		pending_ops.push_back(o);
		items_made++;
	endtask

	// unused fields carry junk so every bit toggles
	task automatic put_entry(input int idx, input longint esoc, input longint eocv);
		add_op(ACT_TABLE, idx, esoc, eocv, longint'($urandom_range(SMP_MAX)),
			1'($urandom_range(1)));
		gen_ocv[idx] = OCV_W'(eocv);
	endtask

	task automatic put_sample(input longint smp, input logic last);
		add_op(ACT_SAMPLE, int'($urandom_range(15)), longint'($urandom_range(65536)),
			longint'($urandom_range(8388607)), smp, last);
	endtask

	task automatic load_table(input bit scrambled);
		longint ocv, step;
		ocv = longint'($urandom_range(8388607, 500000));
		for (int i = 0; i < TBL_DEPTH; i++) begin
			put_entry(i, longint'($urandom_range(65536)),
				scrambled ? longint'($urandom_range(8388607)) : ocv);
			// zero steps give flat segments
			step = ($urandom_range(5) == 0) ? 64'sd0 : longint'($urandom_range(32'(ocv / 12)));
			ocv = ocv - step;
		end
	endtask

	task automatic add_set(input int len);
		longint tlo, thi, uv, base, s, noise;
		tlo = longint'(gen_ocv[0]);
		thi = longint'(gen_ocv[0]);
		for (int i = 1; i < TBL_DEPTH; i++) begin
			if (longint'(gen_ocv[i]) < tlo) tlo = longint'(gen_ocv[i]);
			if (longint'(gen_ocv[i]) > thi) thi = longint'(gen_ocv[i]);
		end
		tlo = (tlo > 150000) ? tlo - 150000 : 0;
		uv = longint'($urandom_range(32'(thi + 150000), 32'(tlo)));
		base = (gen_series > 0) ? uv * gen_series / 1000 : longint'($urandom_range(SMP_MAX));
		if (base > SMP_MAX) base = SMP_MAX;
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(99) < 12) begin
				s = longint'($urandom_range(SMP_MAX));
			end else begin
				noise = base / 100 + 3;
				s = base + longint'($urandom_range(32'(2 * noise))) - noise;
				if (s < 0) s = 0;
				if (s > SMP_MAX) s = SMP_MAX;
			end
			put_sample(s, k == len - 1);
		end
	endtask

	task automatic wait_drained();
		while (pending_ops.size() > 0 || start || soc_expect.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] a, input logic [31:0] d);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (a == ADDR_SERIES)
			cfg_series = d[SER_W-1:0];
		else
			cfg_entries = d[TEN_W-1:0];
	endtask

	initial begin
		int ser_plan [10];
		int ent_plan [10];
		int phase_end, r;
		ser_plan = '{255, 0, 4, 1, 60, 13, 1, 7, 0, 2};
		ent_plan = '{16, 2, 31, 0, 16, 1, 9, 16, 3, 16};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reference table: 4.2 V down to 2.7 V, full to empty
		for (int i = 0; i < TBL_DEPTH; i++)
			put_entry(i, (i == TBL_DEPTH - 1) ? 0 : 65536 - i * 4369, 4200000 - i * 100000);
		put_sample(3456, 1);
		put_sample(SMP_MAX, 1);
		put_sample(0, 1);
		add_op(ACT_TABLE, 15, 0, 2700000, 0, 1);
		put_sample(3500, 0);
		put_sample(3600, 0);
		put_sample(3400, 0);
		put_sample(9000, 1);
		wait_drained();

		for (int ph = 0; ph < 10; ph++) begin
			gen_series = ser_plan[ph];
			if (ph == 9) gen_series = int'($urandom_range(255));
			cfg_write(ADDR_SERIES, gen_series);
			cfg_write(ADDR_ENTRIES, (ph == 9) ? $urandom_range(31) : ent_plan[ph]);
			no_idle = (ph == 4);
			if (ph == 3) begin
				// store full: exactly full, then dropped samples including the final one
				add_set(STORE_DEPTH);
				add_set(STORE_DEPTH + 3);
			end
			phase_end = items_made + PHASE_ITEMS;
			while (items_made < phase_end) begin
				r = int'($urandom_range(99));
				if (r < 8)
					load_table(r < 3);
				else if (r < 18)
					repeat ($urandom_range(3, 1))
						put_entry(int'($urandom_range(15)), longint'($urandom_range(65536)),
							longint'($urandom_range(8388607)));
				add_set(int'($urandom_range(12, 1)));
			end
			wait_drained();
		end
		no_idle = 0;

		if (mismatches == 0 && soc_expect.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#(12.0 * 3000000);
		$display("TEST FAILED");
		$finish;
	end

endmodule
